// ===== hw/rtl/afpb_pkg.sv =====
`default_nettype none

package afpb_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_NUM_CHANNELS = 1'b0,
        CFG_SCALE        = 1'b1
    } t_cfg_index;

    // Item kinds carried on the input tuser
    typedef enum logic [0:0] {
        OP_FRAME = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    localparam int unsigned CODE_W    = 24;
    localparam int unsigned SCALE_W   = 24;
    localparam int unsigned SAMPLE_W  = 32;
    localparam int unsigned NCH_W     = 3;
    localparam int unsigned RCH_W     = 3;
    localparam int unsigned RIDX_W    = 8;
    localparam int unsigned FILL_W    = 8;
    localparam int unsigned MAX_CH    = 4;
    localparam int unsigned FRAC_BITS = 16;

    localparam logic [NCH_W-1:0] NCH_RESET = 3'd4;

    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 48;

    // Bookkeeping that travels with an item into the read stage
    typedef struct packed {
        logic              bank_full;
        logic [FILL_W-1:0] fill;
        logic              read_valid;
        logic              use_data;
        logic [1:0]        ch;
    } t_item_info;

endpackage

`default_nettype wire

// ===== hw/rtl/afpb_ram.sv =====
`default_nettype none

module afpb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/adc_frame_pingpong_buffer.sv =====
`default_nettype none

// ADC frame capture into a ping-pong sample buffer.
// Input stream (s_axis): tuser selects the item kind. A frame item carries
// four channel codes; each enabled channel is scaled to Q16 millivolts and
// written at the fill index of the active bank. When the bank fills, banks
// swap and the filled bank becomes readable. A read item fetches one sample
// of the readable bank. Every item yields exactly one result on m_axis.
// Config channel (cfg): index 0 sets the enabled channel count, index 1 the
// Q16 scale. Write only while the block is idle.
// Pipeline: the synchronous RAM read, then the output register.
// Throughput: one item per cycle unless m_axis stalls or the sweep runs;
// one read per read item, one write per frame fit a 1R1W channel memory.
// Reset: after i_rst_n releases, the block sweeps both banks to zero, one
// row of all channels per cycle, 2 * 2**clog2(BUFFER_DEPTH) rows in all
// (512 at the default depth); s_axis_tready stays low meanwhile.
// Back-pressure: a stalled m_axis holds its result; one further item may
// sit in the read stage, after which s_axis_tready drops until it drains.
module adc_frame_pingpong_buffer #(
    parameter int unsigned BUFFER_DEPTH = 256,
    parameter int unsigned CHANNELS     = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Config write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic                                 i_cfg_index,
    input  wire logic [afpb_pkg::SCALE_W-1:0]         i_cfg_data,
    // Input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata, from bit 0: code_ch0[23:0], code_ch1[47:24], code_ch2[71:48],
    // code_ch3[95:72], read_channel[98:96], read_index[106:99], zero pad
    input  wire logic [afpb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser, from bit 0: opcode
    input  wire logic                                 s_axis_tuser,
    // Output stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata, from bit 0: bank_full[0], fill_count[8:1], read_valid[9],
    // read_value[41:10], zero pad
    output logic      [afpb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    import afpb_pkg::*;

    localparam int unsigned FW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned AW    = FW + 1;
    localparam int unsigned RDEPTH = 2 ** AW;
    localparam logic [FW:0]     DEPTH_F = (FW + 1)'(BUFFER_DEPTH);
    localparam logic [FW+7:0]   DEPTH_I = (FW + 8)'(BUFFER_DEPTH);
    localparam logic [RCH_W-1:0] LAST_CH = RCH_W'(CHANNELS - 1);

    // Configuration
    logic [NCH_W-1:0]   r_num_ch;
    logic [SCALE_W-1:0] r_scale;

    // Buffer control
    logic [FW-1:0] r_fill;
    logic          r_active;
    logic          r_ready_exists;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Read stage and output register
    logic       r_s1_valid;
    t_item_info r_s1_info;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic w_out_take;
    logic w_accept;
    logic w_is_read;
    logic w_frame;
    logic w_rd_en;

    logic [FW:0]   w_fill_inc;
    logic          w_swap;
    logic [FW-1:0] w_fill_next;
    logic [FW+7:0] w_fill_ext;
    logic [FW+7:0] w_ridx_ext;
    logic [RCH_W-1:0] w_rch;
    logic [1:0]    w_ch_sel;
    logic          w_idx_ok;

    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    logic [SAMPLE_W-1:0] w_ram_q   [MAX_CH];
    logic [SAMPLE_W-1:0] w_rd_value;

    t_item_info w_info;

    assign o_cfg_ready = 1'b1;

    // Handshake: the read stage moves on whenever the output register is
    // free or being emptied; after the sweep, take items when the stage can.
    assign w_out_take    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || w_out_take);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_read     = (t_opcode'(s_axis_tuser) == OP_READ);
    assign w_frame       = w_accept && !w_is_read;
    assign w_rd_en       = w_accept && w_is_read;

    // Fill index advance; wrap and swap at the bank depth
    assign w_fill_inc  = {1'b0, r_fill} + (FW + 1)'(1);
    assign w_swap      = (w_fill_inc == DEPTH_F);
    assign w_fill_next = w_swap ? '0 : w_fill_inc[FW-1:0];

    // Read addressing: out-of-range channel falls back to channel 0
    assign w_rch      = s_axis_tdata[98:96];
    assign w_ch_sel   = (w_rch > LAST_CH) ? 2'd0 : w_rch[1:0];
    assign w_ridx_ext = {{FW{1'b0}}, s_axis_tdata[106:99]};
    assign w_idx_ok   = (w_ridx_ext < DEPTH_I);
    assign w_rd_addr  = {~r_active, w_ridx_ext[FW-1:0]};

    assign w_wr_addr  = r_clr_busy ? r_clr_addr : {r_active, r_fill};

    always_comb begin
        w_fill_ext = {8'd0, (w_frame ? w_fill_next : r_fill)};
        w_info.bank_full  = w_frame && w_swap;
        w_info.fill       = w_fill_ext[7:0];
        w_info.read_valid = w_is_read && r_ready_exists;
        w_info.use_data   = w_is_read && r_ready_exists && w_idx_ok;
        w_info.ch         = w_ch_sel;
    end

    // One lane per channel: scale, shift, store
    for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            logic signed [CODE_W:0]   w_code_p1;
            logic signed [SCALE_W:0]  w_scale_s;
            logic signed [49:0]       w_prod;
            logic [SAMPLE_W-1:0]      w_wdata;
            logic                     w_we;

            assign w_code_p1 = $signed({s_axis_tdata[c*CODE_W + CODE_W - 1],
                                        s_axis_tdata[c*CODE_W +: CODE_W]})
                               + (CODE_W + 1)'(signed'(1));
            assign w_scale_s = $signed({1'b0, r_scale});
            // Arithmetic shift of the product floors towards minus infinity
            assign w_prod    = w_code_p1 * w_scale_s;
            assign w_wdata   = r_clr_busy ? '0
                             : w_prod[FRAC_BITS + SAMPLE_W - 1:FRAC_BITS];
            assign w_we      = r_clr_busy || (w_frame && (NCH_W'(c) < r_num_ch));

            afpb_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (RDEPTH)
            ) u_ram (
                .i_clk     (i_clk),
                .i_wr_en   (w_we),
                .i_wr_addr (w_wr_addr),
                .i_wr_data (w_wdata),
                .i_rd_en   (w_rd_en),
                .i_rd_addr (w_rd_addr),
                .o_rd_data (w_ram_q[c])
            );
        end else begin : g_off
            assign w_ram_q[c] = '0;
        end
    end

    assign w_rd_value = r_s1_info.use_data ? w_ram_q[r_s1_info.ch] : '0;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch <= NCH_RESET;
            r_scale  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_NUM_CHANNELS: r_num_ch <= i_cfg_data[NCH_W-1:0];
                CFG_SCALE:        r_scale  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Clearing sweep after reset, then fill and bank control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy     <= 1'b1;
            r_clr_addr     <= '0;
            r_fill         <= '0;
            r_active       <= 1'b0;
            r_ready_exists <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_frame) begin
                r_fill <= w_fill_next;
                if (w_swap) begin
                    r_active       <= ~r_active;
                    r_ready_exists <= 1'b1;
                end
            end
        end
    end

    // Read stage: hold while the output register is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_out_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_info <= w_info;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && r_s1_valid) begin
            r_out_data <= {6'd0, w_rd_value, r_s1_info.read_valid,
                           r_s1_info.fill, r_s1_info.bank_full};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // A filling frame flips the banks and leaves a readable bank behind
    a_swap_flips : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame && w_swap |=> r_ready_exists && (r_active != $past(r_active)))
        else $error("bank swap did not flip active bank");

    // Reads never touch the bank being filled
    a_rd_other_bank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (w_rd_addr[AW-1] != r_active))
        else $error("read addressed the active bank");

    // A stalled read stage keeps its item
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_out_take |=> r_s1_valid && $stable(r_s1_info))
        else $error("read stage lost an item under stall");

    // The sweep ends after covering every address
    a_clr_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> (r_clr_addr == '0))
        else $error("clearing sweep ended early");

    // No item enters while the buffer is being cleared
    a_no_item_clr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |=> !r_s1_valid || $past(r_s1_valid))
        else $error("item accepted during clearing sweep");
`endif

endmodule

`default_nettype wire
